### src/bmpq_pkg.sv
package bmpq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int CAP_W = 5;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;
    localparam int CAP_RESET = (16 > DEPTH) ? DEPTH : 16;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } command_t;

    typedef struct packed {
        logic                      insert;
        logic                      remove;
        logic signed [VALUE_W-1:0] value;
    } bmpq_op_t;

endpackage

### src/bounded_max_priority_queue_top.sv
// A result beat appears in the cycle after its command beat is accepted.
// Throughput: one command per cycle, insert or remove, as long as the result side
// takes beats; the sorted cell chain is updated in the cycle that accepts either command.
// Reset (rst_n, asynchronous, active low) empties the queue and sets the
// capacity to 16 clamped to the depth; stored values are not cleared.
module bounded_max_priority_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,      // capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // value
    input  logic [0:0]  s_tuser,       // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // max_value[31:0], occupancy[36:32], zeros
    output logic [1:0]  m_tuser        // status
);
    import bmpq_pkg::*;

    localparam int CMP_W = CNT_W + CAP_W;

    logic [CAP_W-1:0]          capacity_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] max_reg;
    logic signed [VALUE_W-1:0] max_next;
    logic [OCC_W-1:0]          occ_reg;

    logic      accept;
    logic      is_remove;
    logic      full;
    logic      empty;
    bmpq_op_t  op;

    logic [DEPTH-1:0]          occupied;
    logic [DEPTH-1:0]          ins;
    logic signed [VALUE_W-1:0] vals [DEPTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_remove = (command_t'(s_tuser[0]) == CMD_REMOVE);

    assign full  = (CMP_W'(count_reg) >= CMP_W'(capacity_reg))
                || (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign op.insert = accept && !is_remove && !full;
    assign op.remove = accept && is_remove && !empty;
    assign op.value  = s_tdata;

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        max_next    = '0;
        if (is_remove)
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                max_next   = vals[0];
                count_next = count_reg - CNT_W'(1);
            end
        end
        else
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                      p_ins;
            logic signed [VALUE_W-1:0] p_val;
            logic signed [VALUE_W-1:0] n_val;

            assign occupied[gi] = (CMP_W'(gi) < CMP_W'(count_reg));

            if (gi == 0)
            begin : g_first
                assign p_ins = 1'b0;
                assign p_val = '0;
            end
            else
            begin : g_mid
                assign p_ins = ins[gi-1];
                assign p_val = vals[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign n_val = '0;
            end
            else
            begin : g_body
                assign n_val = vals[gi+1];
            end

            bmpq_cell u_cell (
                .clk      (clk),
                .op       (op),
                .occupied (occupied[gi]),
                .prev_ins (p_ins),
                .prev_val (p_val),
                .next_val (n_val),
                .ins      (ins[gi]),
                .val      (vals[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_W'(CAP_RESET);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            max_reg    <= max_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, occ_reg, max_reg};
    assign m_tuser  = status_reg;

endmodule

### src/bmpq_cell.sv
module bmpq_cell (
    input  logic                               clk,
    input  bmpq_pkg::bmpq_op_t                 op,
    input  logic                               occupied,
    input  logic                               prev_ins,
    input  logic signed [bmpq_pkg::VALUE_W-1:0] prev_val,
    input  logic signed [bmpq_pkg::VALUE_W-1:0] next_val,
    output logic                               ins,
    output logic signed [bmpq_pkg::VALUE_W-1:0] val
);
    import bmpq_pkg::*;

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;

    // The chain is kept in descending order. A new value lands in the first
    // cell that is empty or holds a smaller value; the cells behind it shift
    // back by one.
    assign ins = !occupied || (op.value > val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (op.insert)
        begin
            if (prev_ins)
            begin
                val_next = prev_val;
            end
            else if (ins)
            begin
                val_next = op.value;
            end
        end
        else if (op.remove)
        begin
            val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### tb/tb_bounded_max_priority_queue_top.sv
`timescale 1ns / 100ps

module tb_bounded_max_priority_queue_top;
    import bmpq_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        STEP_BEAT,
        STEP_CAPACITY,
        STEP_SETTLE,
        STEP_PACE,
        STEP_HOLD
    } step_kind_t;

    typedef struct {
        step_kind_t           kind;
        command_t             command;
        logic [VALUE_W-1:0]   value;
        logic [CAP_W-1:0]     capacity;
        int                   send_pct;
        int                   recv_pct;
    } queue_step_t;

    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] max_value;
        logic [OCC_W-1:0]          occupancy;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    queue_step_t pending_steps[$];
    reply_t      predicted_replies[$];

    logic signed [VALUE_W-1:0] model_store [DEPTH];
    int                        model_count = 0;
    logic [CAP_W-1:0]          model_capacity = CAP_W'(CAP_RESET);

    logic s_beat_done = 1'b0;
    logic cfg_beat_done = 1'b0;
    logic settling = 1'b0;
    int   settle_left = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    bounded_max_priority_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic reply_t apply_command(command_t command, logic signed [VALUE_W-1:0] value);
        reply_t reply;
        int     best;
        int     limit;
        reply.status = STATUS_OK;
        reply.max_value = '0;
        limit = (model_capacity > DEPTH) ? DEPTH : int'(model_capacity);
        if (command == CMD_INSERT)
        begin
            if (model_count >= limit)
                reply.status = STATUS_FULL;
            else
            begin
                model_store[model_count] = value;
                model_count++;
            end
        end
        else if (model_count == 0)
            reply.status = STATUS_EMPTY;
        else
        begin
            best = 0;
            for (int i = 1; i < model_count; i++)
                if (model_store[i] > model_store[best])
                    best = i;
            reply.max_value = model_store[best];
            model_store[best] = model_store[model_count - 1];
            model_count--;
        end
        reply.occupancy = OCC_W'(model_count);
        return reply;
    endfunction

    task automatic note_mismatch(string what, logic [39:0] expected, logic [39:0] actual);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch in %s: expected %h, got %h", $time, what, expected, actual);
    endtask

    task automatic push_step(step_kind_t kind, command_t command, logic [VALUE_W-1:0] value,
                             logic [CAP_W-1:0] capacity, int send_pct, int recv_pct);
        queue_step_t step;
        step.kind = kind;
        step.command = command;
        step.value = value;
        step.capacity = capacity;
        step.send_pct = send_pct;
        step.recv_pct = recv_pct;
        pending_steps.push_back(step);
    endtask

    task automatic add_command(command_t command, logic [VALUE_W-1:0] value);
        push_step(STEP_BEAT, command, value, '0, 0, 0);
    endtask

    task automatic add_capacity(logic [CAP_W-1:0] capacity);
        push_step(STEP_SETTLE, CMD_INSERT, '0, '0, 0, 0);
        push_step(STEP_CAPACITY, CMD_INSERT, '0, capacity, 0, 0);
    endtask

    always @(posedge clk)
    begin : watch_beats
        reply_t want;
        s_beat_done = rst_n && s_tvalid && s_tready;
        cfg_beat_done = rst_n && cfg_valid && cfg_ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_beat_done)
                model_capacity = cfg_data;
            if (s_beat_done)
                predicted_replies.push_back(apply_command(command_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (predicted_replies.size() == 0)
                    note_mismatch("unexpected result beat", '0, {m_tuser, m_tdata[37:0]});
                else
                begin
                    want = predicted_replies.pop_front();
                    if (m_tuser !== want.status)
                        note_mismatch("status", 40'(want.status), 40'(m_tuser));
                    if (m_tdata[31:0] !== want.max_value)
                        note_mismatch("max_value", 40'(want.max_value), 40'(m_tdata[31:0]));
                    if (m_tdata[39:32] !== {3'b000, want.occupancy})
                        note_mismatch("occupancy", 40'(want.occupancy), 40'(m_tdata[39:32]));
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_inputs
        queue_step_t step;
        logic        next_s_valid;
        logic        next_cfg_valid;
        next_s_valid = s_tvalid && !s_beat_done;
        next_cfg_valid = cfg_valid && !cfg_beat_done;
        if (rst_n && !next_s_valid && !next_cfg_valid)
        begin
            if (settling)
            begin
                if (predicted_replies.size() != 0)
                    settle_left = SETTLE_CYCLES;
                else if (settle_left > 0)
                    settle_left--;
                else
                    settling = 1'b0;
            end
            else if (pending_steps.size() != 0)
            begin
                case (pending_steps[0].kind)
                    STEP_BEAT:
                    begin
                        if ($urandom_range(0, 99) >= send_idle_pct)
                        begin
                            step = pending_steps.pop_front();
                            next_s_valid = 1'b1;
                            s_tdata <= step.value;
                            s_tuser <= step.command;
                        end
                    end
                    STEP_CAPACITY:
                    begin
                        step = pending_steps.pop_front();
                        next_cfg_valid = 1'b1;
                        cfg_data <= step.capacity;
                    end
                    STEP_SETTLE:
                    begin
                        step = pending_steps.pop_front();
                        settling = 1'b1;
                        settle_left = SETTLE_CYCLES;
                    end
                    STEP_PACE:
                    begin
                        step = pending_steps.pop_front();
                        send_idle_pct <= step.send_pct;
                        recv_idle_pct <= step.recv_pct;
                    end
                    default:
                    begin
                        step = pending_steps.pop_front();
                        hold_requests <= hold_requests + 1;
                    end
                endcase
            end
        end
        s_tvalid <= next_s_valid;
        cfg_valid <= next_cfg_valid;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int                 bias;
        logic [VALUE_W-1:0] value;
        logic [CAP_W-1:0]   capacity;

        push_step(STEP_PACE, CMD_INSERT, '0, '0, 31, 74);
        add_command(CMD_REMOVE, $urandom());
        add_command(CMD_INSERT, 32'h7FFF_FFFF);
        add_command(CMD_INSERT, 32'h8000_0000);
        add_command(CMD_INSERT, 32'hFFFF_FFFF);
        add_command(CMD_INSERT, 32'h0000_0000);
        add_command(CMD_INSERT, 32'd7);
        add_command(CMD_INSERT, 32'd7);
        repeat (7)
            add_command(CMD_REMOVE, $urandom());
        add_capacity(5'd2);
        repeat (3)
            add_command(CMD_INSERT, $urandom());
        add_capacity(5'd0);
        add_command(CMD_INSERT, $urandom());
        repeat (3)
            add_command(CMD_REMOVE, $urandom());
        add_command(CMD_INSERT, $urandom());
        add_capacity(5'd31);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
                push_step(STEP_PACE, CMD_INSERT, '0, '0, 31, 74);
            else if (phase == 1)
                push_step(STEP_PACE, CMD_INSERT, '0, '0, 74, 31);
            else
                push_step(STEP_PACE, CMD_INSERT, '0, '0, 0, 0);
            push_step(STEP_HOLD, CMD_INSERT, '0, '0, 0, 0);
            for (int block = 0; block < 10; block++)
            begin
                if (block % 3 == 2)
                begin
                    case ($urandom_range(0, 5))
                        0: capacity = 5'd0;
                        1: capacity = 5'd16;
                        2: capacity = 5'd31;
                        3: capacity = 5'd1;
                        default: capacity = CAP_W'($urandom_range(0, 31));
                    endcase
                    add_capacity(capacity);
                end
                bias = (block == 0) ? 90 : $urandom_range(15, 85);
                for (int n = 0; n < 40; n++)
                begin
                    case ($urandom_range(0, 3))
                        0: value = $urandom_range(0, 7) - 4;
                        1: value = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        default: value = $urandom();
                    endcase
                    add_command(($urandom_range(0, 99) < bias) ? CMD_INSERT : CMD_REMOVE, value);
                end
            end
        end

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_steps.size() != 0 || settling || s_tvalid || cfg_valid
               || predicted_replies.size() != 0)
            @(negedge clk);
        repeat (4 * SETTLE_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
